// ===== hw/rtl/constant_velocity_kalman_filter_unit_defines.svh =====
// Assertion macros for the constant-velocity Kalman filter unit.
// Used by the top level only; no dependencies.
`ifndef CONSTANT_VELOCITY_KALMAN_FILTER_UNIT_DEFINES_SVH
`define CONSTANT_VELOCITY_KALMAN_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CVKF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CVKF_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CVKF_ASSERT(label, prop, msg)
`define CVKF_NEVER(label, expr, msg)
`endif
`endif

// ===== hw/rtl/cvkf_pkg.sv =====
// Shared types and constants for the constant-velocity Kalman filter unit.
// No dependencies.
`default_nettype none
package cvkf_pkg;
    localparam int AXES_DEF = 6;
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int FRAC = 40;
    localparam int REG_WIDTH = 3;
    localparam logic [REG_WIDTH-1:0] REG_DT = 3'd0;
    localparam logic [REG_WIDTH-1:0] REG_U  = 3'd1;
    localparam logic [REG_WIDTH-1:0] REG_QP = 3'd2;
    localparam logic [REG_WIDTH-1:0] REG_QC = 3'd3;
    localparam logic [REG_WIDTH-1:0] REG_QV = 3'd4;
    localparam logic [REG_WIDTH-1:0] REG_R  = 3'd5;
    localparam logic [63:0] DT_RST = 64'd5497558139;
    localparam logic [63:0] QP_RST = 64'd68719;
    localparam logic [63:0] QC_RST = 64'd27487791;
    localparam logic [63:0] QV_RST = 64'd10995116278;
    localparam logic [63:0] R_RST  = 64'd27487791;
    localparam logic [63:0] ONE_Q  = 64'd1 << FRAC;
endpackage
`default_nettype wire

// ===== hw/rtl/constant_velocity_kalman_filter_unit.sv =====
// Constant-velocity Kalman filter, six axes, one shared multiplier and divider.
// Depends on cvkf_pkg and constant_velocity_kalman_filter_unit_defines.svh.
//
// channel  dir  signals                  content
// s_axis   in   tvalid/tready/tdata/tuser tdata: meas_x..meas_rz; tuser: func
// m_axis   out  tvalid/tready/tdata/tlast tdata: axis, position, velocity
// cfg      in   valid/ready/index/data   register writes
//
// Each multiply forms four 32x32 partial products, then the result is used.
// Predict: accept, two multiplies per axis, three for the covariance, then
// the output and wait states for each result. Update: two serial divides
// (one quotient bit per cycle) before the per-axis multiplies; a zero
// divisor skips the divides. Each result waits in the output register, and
// the sequence stalls while it is not taken.
// rst_n clears state to zero estimates and unit covariance. s_axis_tready is
// high only while the sequencer is idle.
`default_nettype none
`include "constant_velocity_kalman_filter_unit_defines.svh"
module constant_velocity_kalman_filter_unit #(
    parameter int AXES = cvkf_pkg::AXES_DEF,
    parameter int VALUE_WIDTH = cvkf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // meas_x, meas_y, meas_z, meas_rx, meas_ry, meas_rz from bit 0 up
    input  wire logic [6*VALUE_WIDTH-1:0] s_axis_tdata,
    // func
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // axis, position_estimate, velocity_estimate, zero fill, from bit 0 up
    output logic [((3+2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic      m_axis_tlast,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [cvkf_pkg::REG_WIDTH-1:0] cfg_index,
    input  wire logic [VALUE_WIDTH-1:0] cfg_data
);
    import cvkf_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int OUT_W = ((3 + 2*W + 7) / 8) * 8;
    localparam int DIV_STEPS = 64 + FRAC;
    localparam int DCW = $clog2(DIV_STEPS + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PAX   = 4'd1;  // predict: dt*vel
    localparam logic [3:0] S_PAX2  = 4'd2;  // predict: dt*u
    localparam logic [3:0] S_PCV   = 4'd3;  // predict covariance steps
    localparam logic [3:0] S_UDIV  = 4'd4;  // gain divisions
    localparam logic [3:0] S_UAX   = 4'd5;  // update: k1*e
    localparam logic [3:0] S_UAX2  = 4'd6;  // update: k2*e
    localparam logic [3:0] S_UCV   = 4'd7;  // update covariance steps
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [W-1:0] dt_reg, qp_reg, qc_reg, qv_reg, r_reg;
    logic signed [W-1:0] u_reg;
    logic signed [W-1:0] pos_reg [AXES];
    logic signed [W-1:0] vel_reg [AXES];
    logic signed [W-1:0] meas_reg [AXES];
    logic signed [W-1:0] cpp_reg, cpv_reg, cvv_reg;
    logic signed [W-1:0] a_reg, b_reg, k1_reg, k2_reg, e_reg;
    logic [AW-1:0] ax_reg;
    logic [2:0] step_reg;
    logic out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic out_last_reg;

    // saturating helpers
    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
        return s[W-1:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [W-1:0] x);
        logic signed [63:0] y;
        y = 64'(x);
        return y[63] ? 64'(-y) : 64'(y);
    endfunction

    // Shared multiplier on magnitudes: one 32x32 partial product per cycle,
    // accumulated in macc_reg; the result is then floored and saturated.
    logic signed [W-1:0] ma, mb;
    logic [63:0] ma_mag, mb_mag;
    logic [31:0] mpa, mpb;
    logic [63:0] mpart;
    logic [127:0] mpart_sh;
    logic [127:0] macc_reg;
    logic [2:0] mcnt_reg;
    logic mdone;
    logic signed [W-1:0] mres;

    assign ma_mag = mag64(ma);
    assign mb_mag = mag64(mb);
    assign mpa = mcnt_reg[0] ? ma_mag[63:32] : ma_mag[31:0];
    assign mpb = mcnt_reg[1] ? mb_mag[63:32] : mb_mag[31:0];
    assign mpart = mpa * mpb;
    assign mdone = (mcnt_reg == 3'd4);

    always_comb
    begin
        case (mcnt_reg[1:0])
            2'd0:    mpart_sh = {64'd0, mpart};
            2'd3:    mpart_sh = {mpart, 64'd0};
            default: mpart_sh = {32'd0, mpart, 32'd0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mcnt_reg == 3'd0) macc_reg <= mpart_sh;
        else if (!mdone) macc_reg <= macc_reg + mpart_sh;
    end

    always_comb
    begin
        logic mneg;
        logic [127:0] mq;
        mneg = ma[W-1] ^ mb[W-1];
        mq = (macc_reg >> FRAC) + 128'(mneg && (macc_reg[FRAC-1:0] != '0));
        if (!mneg)
            mres = (mq > 128'(VMAX)) ? VMAX : mq[W-1:0];
        else if (mq > 128'(VMAX) + 128'd1)
            mres = VMIN;
        else
            mres = W'(-mq);
    end

    always_comb
    begin
        ma = $signed(dt_reg);
        mb = '0;
        unique case (state_reg)
            S_PAX:  mb = vel_reg[ax_reg];
            S_PAX2: mb = u_reg;
            S_PCV:
            begin
                case (step_reg)
                    3'd0:    mb = cpv_reg;
                    3'd1:    mb = cvv_reg;
                    default: mb = b_reg;
                endcase
            end
            S_UAX:  begin ma = k1_reg; mb = e_reg; end
            S_UAX2: begin ma = k2_reg; mb = e_reg; end
            S_UCV:
            begin
                case (step_reg)
                    3'd0:    begin ma = k2_reg; mb = cpv_reg; end
                    3'd1:    begin ma = k1_reg; mb = cpv_reg; end
                    default: begin ma = k1_reg; mb = cpp_reg; end
                endcase
            end
            default: ;
        endcase
    end

    // Restoring divider, one quotient bit per cycle, magnitudes in 64 bits.
    logic [63:0] dn_reg, dd_reg, rem_reg, q_reg;
    logic dovf_reg, dneg_reg, dsel_reg;
    logic [DCW-1:0] dcnt_reg;
    logic signed [W-1:0] s_val;
    logic signed [W-1:0] dres;

    assign s_val = sadd(cpp_reg, $signed(r_reg));

    always_comb
    begin
        if (dovf_reg || (!dneg_reg && q_reg > 64'(VMAX)))
            dres = dneg_reg ? VMIN : VMAX;
        else if (dneg_reg && q_reg > 64'(VMAX) + 64'd1)
            dres = VMIN;
        else
            dres = dneg_reg ? W'(-q_reg) : W'(q_reg);
    end

    // divider step
    logic [63:0] rem_sh;
    logic rem_top, take;
    always_comb
    begin
        rem_top = rem_reg[63];
        rem_sh = {rem_reg[62:0], (dcnt_reg < DCW'(64)) ? dn_reg[63] : 1'b0};
        take = rem_top || (rem_sh >= dd_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = s_axis_tuser ? S_UDIV : S_PAX;
            S_PAX:   if (mdone) state_next = S_PAX2;
            S_PAX2:  if (mdone)
                         state_next = (ax_reg == AW'(AXES-1)) ? S_PCV : S_PAX;
            S_PCV:   if (mdone && step_reg == 3'd2) state_next = S_OUT;
            S_UDIV:  if (dsel_reg && dcnt_reg == DCW'(DIV_STEPS)) state_next = S_UAX;
            S_UAX:   if (mdone) state_next = S_UAX2;
            S_UAX2:  if (mdone)
                         state_next = (ax_reg == AW'(AXES-1)) ? S_UCV : S_UAX;
            S_UCV:   if (mdone && step_reg == 3'd2) state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || m_axis_tready) state_next = S_WAIT;
            S_WAIT:  if (!out_valid_reg || m_axis_tready)
                         state_next = out_last_reg ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dt_reg <= W'(DT_RST);
            u_reg <= '0;
            qp_reg <= W'(QP_RST);
            qc_reg <= W'(QC_RST);
            qv_reg <= W'(QV_RST);
            r_reg <= W'(R_RST);
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            cpp_reg <= W'(ONE_Q);
            cpv_reg <= '0;
            cvv_reg <= W'(ONE_Q);
            ax_reg <= '0;
            step_reg <= '0;
            mcnt_reg <= '0;
            dcnt_reg <= '0;
            dsel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_DT: dt_reg <= {1'b0, cfg_data[W-2:0]};
                            REG_U:  u_reg <= cfg_data;
                            REG_QP: qp_reg <= {1'b0, cfg_data[W-2:0]};
                            REG_QC: qc_reg <= {1'b0, cfg_data[W-2:0]};
                            REG_QV: qv_reg <= {1'b0, cfg_data[W-2:0]};
                            REG_R:  r_reg <= {1'b0, cfg_data[W-2:0]};
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid)
                    begin
                        for (int i = 0; i < AXES; i++)
                            meas_reg[i] <= (i < 6) ? s_axis_tdata[i*W +: W] : '0;
                        ax_reg <= '0;
                        step_reg <= '0;
                        mcnt_reg <= '0;
                        dcnt_reg <= '0;
                        dsel_reg <= 1'b0;
                        k1_reg <= '0;
                        k2_reg <= '0;
                        // first division: cov_pp / s
                        dn_reg <= mag64(cpp_reg);
                        dd_reg <= mag64(s_val);
                        dneg_reg <= cpp_reg[W-1] ^ s_val[W-1];
                        rem_reg <= '0;
                        q_reg <= '0;
                        dovf_reg <= 1'b0;
                    end
                end
                S_PAX:
                begin
                    mcnt_reg <= mdone ? 3'd0 : mcnt_reg + 3'd1;
                    if (mdone) pos_reg[ax_reg] <= sadd(pos_reg[ax_reg], mres);
                end
                S_PAX2:
                begin
                    mcnt_reg <= mdone ? 3'd0 : mcnt_reg + 3'd1;
                    if (mdone)
                    begin
                        vel_reg[ax_reg] <= sadd(vel_reg[ax_reg], mres);
                        ax_reg <= (ax_reg == AW'(AXES-1)) ? '0 : ax_reg + 1'b1;
                    end
                end
                S_PCV:
                begin
                    mcnt_reg <= mdone ? 3'd0 : mcnt_reg + 3'd1;
                    if (mdone)
                    begin
                        step_reg <= step_reg + 1'b1;
                        case (step_reg)
                            3'd0: a_reg <= sadd(cpp_reg, mres);
                            3'd1: b_reg <= sadd(cpv_reg, mres);
                            default:
                            begin
                                cpp_reg <= sadd(sadd(a_reg, mres), $signed(qp_reg));
                                cpv_reg <= sadd(b_reg, $signed(qc_reg));
                                cvv_reg <= sadd(cvv_reg, $signed(qv_reg));
                            end
                        endcase
                    end
                end
                S_UDIV:
                begin
                    if (s_val == '0)
                    begin
                        // zero divisor: gains stay zero
                        dsel_reg <= 1'b1;
                        dcnt_reg <= DCW'(DIV_STEPS);
                    end
                    else if (dcnt_reg == DCW'(DIV_STEPS))
                    begin
                        if (!dsel_reg)
                        begin
                            k1_reg <= dres;
                            dsel_reg <= 1'b1;
                            dcnt_reg <= '0;
                            dn_reg <= mag64(cpv_reg);
                            dneg_reg <= cpv_reg[W-1] ^ s_val[W-1];
                            rem_reg <= '0;
                            q_reg <= '0;
                            dovf_reg <= 1'b0;
                        end
                        else
                        begin
                            k2_reg <= dres;
                        end
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                        dn_reg <= {dn_reg[62:0], 1'b0};
                        if (q_reg[63]) dovf_reg <= 1'b1;
                        rem_reg <= take ? rem_sh - dd_reg : rem_sh;
                        q_reg <= {q_reg[62:0], take};
                    end
                    if (state_next == S_UAX)
                        e_reg <= ssub(meas_reg[0], pos_reg[0]);
                end
                S_UAX:
                begin
                    mcnt_reg <= mdone ? 3'd0 : mcnt_reg + 3'd1;
                    if (mdone) pos_reg[ax_reg] <= sadd(pos_reg[ax_reg], mres);
                end
                S_UAX2:
                begin
                    mcnt_reg <= mdone ? 3'd0 : mcnt_reg + 3'd1;
                    if (mdone)
                    begin
                        vel_reg[ax_reg] <= sadd(vel_reg[ax_reg], mres);
                        if (ax_reg != AW'(AXES-1))
                        begin
                            ax_reg <= ax_reg + 1'b1;
                            e_reg <= ssub(meas_reg[ax_reg + 1'b1], pos_reg[ax_reg + 1'b1]);
                        end
                        else
                            ax_reg <= '0;
                    end
                end
                S_UCV:
                begin
                    mcnt_reg <= mdone ? 3'd0 : mcnt_reg + 3'd1;
                    if (mdone)
                    begin
                        step_reg <= step_reg + 1'b1;
                        case (step_reg)
                            3'd0: a_reg <= mres;   // k2*cov_pv
                            3'd1: b_reg <= mres;   // k1*cov_pv
                            default:
                            begin
                                cvv_reg <= ssub(cvv_reg, a_reg);
                                cpv_reg <= ssub(cpv_reg, b_reg);
                                cpp_reg <= ssub(cpp_reg, mres);
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= OUT_W'({vel_reg[ax_reg], pos_reg[ax_reg],
                                                3'(ax_reg)});
                        out_last_reg <= (ax_reg == AW'(AXES-1));
                        if (ax_reg != AW'(AXES-1)) ax_reg <= ax_reg + 1'b1;
                    end
                end
                S_WAIT: ;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

    logic last_taken;
    assign last_taken = (state_reg == S_WAIT) && out_last_reg
                        && (!out_valid_reg || m_axis_tready);

    `CVKF_NEVER(a_busy_no_accept, (state_reg != S_IDLE) && s_axis_tready, "ready while busy")
    `CVKF_ASSERT(a_ax_range, ax_reg <= AW'(AXES-1), "axis counter out of range")
    `CVKF_ASSERT(a_div_cnt, dcnt_reg <= DCW'(DIV_STEPS), "divider overran")
    `CVKF_ASSERT(a_mul_cnt, mcnt_reg <= 3'd4, "multiplier counter overran")
    `CVKF_ASSERT(a_idle_after_last, last_taken |=> state_reg == S_IDLE, "no return to idle")
endmodule
`default_nettype wire
